// File: rtl/uart_pkg.sv
// Package: shared constants and status types of the 8N1 UART transceiver.
package uart_pkg;

  // Bit timer and frame geometry
  localparam int TIMER_WIDTH = 16;
  localparam int DATA_BITS   = 8;
  localparam int IDX_WIDTH   = 4;
  localparam int ITEM_WIDTH  = 16;

  localparam logic [TIMER_WIDTH-1:0] BIT_TIME_RESET = TIMER_WIDTH'(104);

  // Frame step indexes: start bit, data bits 1..8, stop bit, trailing period
  localparam logic [IDX_WIDTH-1:0] IDX_START = IDX_WIDTH'(0);
  localparam logic [IDX_WIDTH-1:0] IDX_STOP  = IDX_WIDTH'(9);
  localparam logic [IDX_WIDTH-1:0] IDX_DONE  = IDX_WIDTH'(10);

  // Transmitter status seen at the result port
  typedef struct packed {
    logic busy;
    logic level;
  } tx_status_t;

  // Receiver status seen at the result port
  typedef struct packed {
    logic                 ready;
    logic [DATA_BITS-1:0] data;
  } rx_status_t;

  // Timer period: a zero setting counts as one tick
  function automatic logic [TIMER_WIDTH-1:0] period_of(input logic [TIMER_WIDTH-1:0] bt);
    logic [TIMER_WIDTH-1:0] p;
    p = (bt == '0) ? TIMER_WIDTH'(1) : bt;
    return p;
  endfunction

endpackage

// File: rtl/uart_tx_core.sv
// Transmitter: free-running bit timer and 8N1 frame shifter.
module uart_tx_core
  import uart_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [TIMER_WIDTH-1:0] period,
  input  logic                   tx_start,
  input  logic [DATA_BITS-1:0]   tx_byte,
  output tx_status_t             status
);

  logic [TIMER_WIDTH-1:0] tick_count, tick_count_next;
  logic [IDX_WIDTH-1:0]   bit_index, bit_index_next;
  logic [DATA_BITS-1:0]   shift, shift_next;
  logic                   active, active_next;
  logic                   level, level_next;
  logic [TIMER_WIDTH:0]   count_inc;
  logic                   fire;

  // Bit timer: fires when the count plus one reaches or passes the period
  assign count_inc = {1'b0, tick_count} + (TIMER_WIDTH+1)'(1);
  assign fire      = (count_inc >= {1'b0, period});

  // Request first, then the bit event on the request-updated state
  always_comb begin
    active_next    = active;
    shift_next     = shift;
    bit_index_next = bit_index;
    level_next     = level;
    if (tx_start && !active) begin
      active_next    = 1'b1;
      shift_next     = tx_byte;
      bit_index_next = IDX_START;
    end
    tick_count_next = fire ? '0 : count_inc[TIMER_WIDTH-1:0];
    if (fire && active_next) begin
      if (bit_index_next == IDX_START) begin
        level_next     = 1'b0;
        bit_index_next = bit_index_next + IDX_WIDTH'(1);
      end else if (bit_index_next < IDX_STOP) begin
        level_next     = shift_next[0];
        shift_next     = {1'b0, shift_next[DATA_BITS-1:1]};
        bit_index_next = bit_index_next + IDX_WIDTH'(1);
      end else if (bit_index_next == IDX_STOP) begin
        level_next     = 1'b1;
        bit_index_next = IDX_DONE;
      end else begin
        bit_index_next = IDX_START;
        active_next    = 1'b0;
      end
    end
  end

  // State, advanced once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      bit_index  <= IDX_START;
      shift      <= '0;
      active     <= 1'b0;
      level      <= 1'b1;
    end else if (step) begin
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift      <= shift_next;
      active     <= active_next;
      level      <= level_next;
    end
  end

  assign status.busy  = active;
  assign status.level = level;

endmodule

// File: rtl/uart_rx_core.sv
// Receiver: start-edge detect, mid-bit sampling, byte hold and ready flag.
module uart_rx_core
  import uart_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [TIMER_WIDTH-1:0] bit_time,
  input  logic [TIMER_WIDTH-1:0] period,
  input  logic                   rx_line,
  input  logic                   rx_ack,
  output rx_status_t             status
);

  logic [TIMER_WIDTH-1:0] tick_count, tick_count_next;
  logic [IDX_WIDTH-1:0]   bit_index, bit_index_next;
  logic [DATA_BITS-1:0]   shift, shift_next;
  logic                   active, active_next;
  logic                   prev_level;
  logic [DATA_BITS-1:0]   hold, hold_next;
  logic                   flag, flag_next;
  logic [TIMER_WIDTH-2:0] half;
  logic [TIMER_WIDTH-1:0] start_delay;
  logic [TIMER_WIDTH-1:0] count_dec;
  logic                   got;

  // Delay from the falling edge to the start-bit sample, at least one tick
  assign half        = bit_time[TIMER_WIDTH-1:1];
  assign start_delay = (half > (TIMER_WIDTH-1)'(1)) ?
                       {1'b0, half - (TIMER_WIDTH-1)'(1)} : TIMER_WIDTH'(1);
  assign count_dec   = (tick_count != '0) ? tick_count - TIMER_WIDTH'(1) : tick_count;

  always_comb begin
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_next      = shift;
    active_next     = active;
    hold_next       = hold;
    got             = 1'b0;
    if (!active) begin
      // Idle: wait for a falling edge
      if (prev_level && !rx_line) begin
        active_next     = 1'b1;
        bit_index_next  = IDX_START;
        tick_count_next = start_delay;
      end
    end else begin
      tick_count_next = count_dec;
      if (count_dec == '0) begin
        tick_count_next = period;
        if (bit_index == IDX_START) begin
          // high start sample is a false start
          if (rx_line) begin
            active_next = 1'b0;
          end else begin
            shift_next     = '0;
            bit_index_next = bit_index + IDX_WIDTH'(1);
          end
        end else if (bit_index < IDX_STOP) begin
          shift_next     = {rx_line, shift[DATA_BITS-1:1]};
          bit_index_next = bit_index + IDX_WIDTH'(1);
        end else begin
          // stop bit: keep the byte only on a high stop level
          if (rx_line) begin
            hold_next = shift;
            got       = 1'b1;
          end
          active_next    = 1'b0;
          bit_index_next = IDX_START;
        end
      end
    end
    // a new byte outranks a same-tick acknowledge
    flag_next = got | (flag & ~rx_ack);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      bit_index  <= IDX_START;
      shift      <= '0;
      active     <= 1'b0;
      prev_level <= 1'b1;
      hold       <= '0;
      flag       <= 1'b0;
    end else if (step) begin
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift      <= shift_next;
      active     <= active_next;
      prev_level <= rx_line;
      hold       <= hold_next;
      flag       <= flag_next;
    end
  end

  assign status.ready = flag;
  assign status.data  = hold;

endmodule

// File: rtl/uart_8n1_bit_timed_transceiver.sv
// Top level: 8N1 UART transceiver stepped once per timer-tick item.
// A result item is offered once its tick item has left the input register and stepped the state.
// Throughput: one item per cycle while the result side is ready; a waiting
// result lets at most one further tick into the input register.
// Reset (rst, synchronous, active high): line idle high, transmitter and
// receiver idle, ready flag clear, bit_time back to 104; no clearing pass.
module uart_8n1_bit_timed_transceiver
  import uart_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [TIMER_WIDTH-1:0] cfg_wdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [ITEM_WIDTH-1:0]  s_axis_tdata,  // rx_line, tx_start, tx_byte[7:0], rx_ack
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [ITEM_WIDTH-1:0]  m_axis_tdata   // tx_line, tx_busy, rx_byte[7:0], rx_ready
);

  logic [TIMER_WIDTH-1:0] bit_time;
  logic [TIMER_WIDTH-1:0] period;
  logic                   in_valid;
  logic [ITEM_WIDTH-1:0]  in_data;
  logic                   out_valid;
  logic                   advance;
  tx_status_t             tx_status;
  rx_status_t             rx_status;

  // Bit time register
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_time <= BIT_TIME_RESET;
    end else if (cfg_we) begin
      bit_time <= cfg_wdata;
    end
  end

  assign period = period_of(bit_time);

  // Step the state when a held item can hand its result on
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data <= s_axis_tdata;
    end
  end

  // Result valid; the payload is the state itself, which holds while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  uart_tx_core u_tx (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .period   (period),
    .tx_start (in_data[1]),
    .tx_byte  (in_data[9:2]),
    .status   (tx_status)
  );

  uart_rx_core u_rx (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .bit_time (bit_time),
    .period   (period),
    .rx_line  (in_data[0]),
    .rx_ack   (in_data[10]),
    .status   (rx_status)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, rx_status.ready, rx_status.data,
                          tx_status.busy, tx_status.level};

`ifndef SYNTHESIS
  // A low transmit level only ever occurs inside a frame
  a_low_means_busy: assert property (@(posedge clk) disable iff (rst)
    !tx_status.level |-> tx_status.busy)
    else $error("tx line low while transmitter idle");

  // State moves only when an item is stepped
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(tx_status) && $stable(rx_status))
    else $error("state changed without a stepped item");

  // Ready flag rises only from a stepped item
  a_ready_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(rx_status.ready) |-> $past(advance))
    else $error("rx ready rose without a stepped item");
`endif

endmodule

// File: tb/tb.sv
// Testbench for the 8N1 UART transceiver: tick stream in, line status out, checked per item.
`timescale 1ns / 100ps

module tb;
  import uart_pkg::*;

  // One tick item, lowest bit first: rx_line, tx_start, tx_byte, rx_ack
  typedef struct packed {
    logic [ITEM_WIDTH-12:0] pad;
    logic                   rx_ack;
    logic [DATA_BITS-1:0]   tx_byte;
    logic                   tx_start;
    logic                   rx_line;
  } tick_t;

  // One status item, lowest bit first: tx_line, tx_busy, rx_byte, rx_ready
  typedef struct packed {
    logic [ITEM_WIDTH-12:0] pad;
    logic                   rx_ready;
    logic [DATA_BITS-1:0]   rx_byte;
    logic                   tx_busy;
    logic                   tx_line;
  } status_t;

  // Line model of the transceiver and the queue of status items it predicts
  class uart_scoreboard;
    logic [TIMER_WIDTH-1:0] bit_time;
    logic [TIMER_WIDTH-1:0] tx_count;
    logic [IDX_WIDTH-1:0]   tx_index;
    logic [DATA_BITS-1:0]   tx_shift;
    logic                   tx_active;
    logic                   tx_level;
    logic [TIMER_WIDTH-1:0] rx_count;
    logic [IDX_WIDTH-1:0]   rx_index;
    logic [DATA_BITS-1:0]   rx_shift;
    logic                   rx_active;
    logic                   rx_prev;
    logic [DATA_BITS-1:0]   rx_hold;
    logic                   rx_flag;
    status_t                expected_status[$];
    int                     errors;
    int                     seen;

    function new();
      bit_time  = BIT_TIME_RESET;
      tx_count  = '0;
      tx_index  = IDX_START;
      tx_shift  = '0;
      tx_active = 1'b0;
      tx_level  = 1'b1;
      rx_count  = '0;
      rx_index  = IDX_START;
      rx_shift  = '0;
      rx_active = 1'b0;
      rx_prev   = 1'b1;
      rx_hold   = '0;
      rx_flag   = 1'b0;
      errors    = 0;
      seen      = 0;
    endfunction

    function void set_bit_time(logic [TIMER_WIDTH-1:0] v);
      bit_time = v;
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    // Advance the model by one accepted tick and queue the status it leaves
    function void note_tick(tick_t t);
      logic [TIMER_WIDTH:0]   per;
      logic [TIMER_WIDTH-1:0] delay;
      logic                   got;
      status_t                s;
      // zero period counts as one; a 16-bit register cannot pass 2^16
      per = (bit_time == '0) ? (TIMER_WIDTH+1)'(1) : {1'b0, bit_time};
      got = 1'b0;

      // request taken only when the transmitter is idle
      if (t.tx_start && !tx_active) begin
        tx_active = 1'b1;
        tx_shift  = t.tx_byte;
        tx_index  = IDX_START;
      end

      // free-running bit timer drives the transmit steps
      if ({1'b0, tx_count} + (TIMER_WIDTH+1)'(1) >= per) begin
        tx_count = '0;
        if (tx_active) begin
          if (tx_index == IDX_START) begin
            tx_level = 1'b0;
            tx_index = IDX_START + 1'b1;
          end else if (tx_index < IDX_STOP) begin
            tx_level = tx_shift[0];
            tx_shift = tx_shift >> 1;
            tx_index = tx_index + 1'b1;
          end else if (tx_index == IDX_STOP) begin
            tx_level = 1'b1;
            tx_index = IDX_DONE;
          end else begin
            tx_index  = IDX_START;
            tx_active = 1'b0;
          end
        end
      end else begin
        tx_count = tx_count + 1'b1;
      end

      // receiver: edge hunt while idle, then timed samples
      if (!rx_active) begin
        if (rx_prev && !t.rx_line) begin
          delay     = bit_time >> 1;
          delay     = (delay > 1) ? delay - 1'b1 : TIMER_WIDTH'(1);
          rx_active = 1'b1;
          rx_index  = IDX_START;
          rx_count  = delay;
        end
      end else begin
        if (rx_count > 0) rx_count = rx_count - 1'b1;
        if (rx_count == 0) begin
          rx_count = per[TIMER_WIDTH-1:0];
          if (rx_index == IDX_START) begin
            // high at the start-bit point: false start
            if (t.rx_line) begin
              rx_active = 1'b0;
            end else begin
              rx_shift = '0;
              rx_index = IDX_START + 1'b1;
            end
          end else if (rx_index < IDX_STOP) begin
            rx_shift = {t.rx_line, rx_shift[DATA_BITS-1:1]};
            rx_index = rx_index + 1'b1;
          end else begin
            // low stop bit drops the byte
            if (t.rx_line) begin
              rx_hold = rx_shift;
              got     = 1'b1;
            end
            rx_active = 1'b0;
            rx_index  = IDX_START;
          end
        end
      end
      rx_prev = t.rx_line;

      // a new byte outranks a same-tick acknowledge
      if (t.rx_ack) rx_flag = 1'b0;
      if (got) rx_flag = 1'b1;

      s          = '0;
      s.tx_line  = tx_level;
      s.tx_busy  = tx_active;
      s.rx_byte  = rx_hold;
      s.rx_ready = rx_flag;
      expected_status.push_back(s);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task check_status(status_t g);
      status_t e;
      if (expected_status.size() == 0) begin
        report($sformatf("status %h with no tick waiting", g));
      end else begin
        e = expected_status.pop_front();
        if (g.tx_line !== e.tx_line || g.tx_busy !== e.tx_busy ||
            g.rx_byte !== e.rx_byte || g.rx_ready !== e.rx_ready)
          report($sformatf("item %0d: tx_line %b/%b tx_busy %b/%b rx_byte %h/%h rx_ready %b/%b",
                           seen, g.tx_line, e.tx_line, g.tx_busy, e.tx_busy,
                           g.rx_byte, e.rx_byte, g.rx_ready, e.rx_ready));
      end
      seen++;
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [TIMER_WIDTH-1:0] cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [ITEM_WIDTH-1:0]  s_axis_tdata = '0;   // rx_line, tx_start, tx_byte[7:0], rx_ack
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [ITEM_WIDTH-1:0]  m_axis_tdata;        // tx_line, tx_busy, rx_byte[7:0], rx_ready

  uart_scoreboard sb;
  int             burst_left = 0;
  int             sink_run = 0;
  bit             sink_on = 1'b0;
  logic [1:0]     line_plan[$];                // {ack bias, rx level} per tick

  uart_8n1_bit_timed_transceiver u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: alternating ready and stall runs, now and then a long ready stretch
  always @(posedge clk) begin
    if (sink_run == 0) begin
      sink_on = !sink_on;
      if (sink_on) sink_run = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
      else sink_run = $urandom_range(1, 6);
    end
    sink_run = sink_run - 1;
    m_axis_tready <= sink_on;
  end

  // Every accepted status item goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_status(status_t'(m_axis_tdata));
  end

  function automatic tick_t mk_tick(logic line, logic start, logic [7:0] b, logic ack);
    tick_t t;
    t          = '0;
    t.rx_line  = line;
    t.tx_start = start;
    t.tx_byte  = b;
    t.rx_ack   = ack;
    return t;
  endfunction

  // Offer one tick, wait for the handshake, then maybe end the burst with a gap
  task automatic send_tick(input tick_t t);
    int gap;
    s_axis_tdata  <= t;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_tick(t);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Tick with given rx level; ack more likely around a stop bit
  task automatic push_tick(input logic line, input logic hot);
    send_tick(mk_tick(line, $urandom_range(0, 15) == 0, 8'($urandom),
                      hot ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 39) == 0)));
  endtask

  // Hold the sender until every status item is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_bit_time(input logic [TIMER_WIDTH-1:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_bit_time(v);
  endtask

  function automatic void push_level(logic level, int count, logic hot);
    repeat (count) line_plan.push_back({hot, level});
  endfunction

  // Next piece of rx waveform: mostly frames, some framing errors, glitches, noise
  function automatic void plan_segment(int bt, bit quiet);
    int         pick;
    int         d;
    logic [7:0] b;
    if (quiet) begin
      line_plan.push_back(2'b01);
      return;
    end
    pick = $urandom_range(0, 99);
    d    = (bt / 2 > 1) ? bt / 2 - 1 : 1;
    if (pick < 75) begin
      b = 8'($urandom);
      push_level(1'b0, bt, 1'b0);
      for (int i = 0; i < 8; i++) push_level(b[i], bt, 1'b0);
      push_level(pick < 65, bt, 1'b1);
      push_level(1'b1, $urandom_range(1, 2 * bt), 1'b0);
    end else if (pick < 85) begin
      // low too short to reach the start-bit point
      push_level(1'b0, $urandom_range(1, d), 1'b0);
      push_level(1'b1, bt + $urandom_range(0, bt), 1'b0);
    end else if (pick < 93) begin
      repeat ($urandom_range(1, 3 * bt)) line_plan.push_back({1'b0, 1'($urandom)});
      line_plan.push_back(2'b01);
    end else begin
      push_level(1'b1, $urandom_range(1, 4 * bt), 1'b0);
    end
  endfunction

  // One setting of bit_time: idle write, n planned ticks, then an idle tail unless quiet
  task automatic run_phase(input logic [TIMER_WIDTH-1:0] bt, input int n, input bit quiet);
    int         sent;
    logic [1:0] p;
    drain();
    write_bit_time(bt);
    line_plan.delete();
    sent = 0;
    while (sent < n) begin
      if (line_plan.size() == 0) plan_segment(int'(bt), quiet);
      p = line_plan.pop_front();
      push_tick(p[0], p[1]);
      sent++;
    end
    // long enough for any frame in flight to finish before the next write
    if (!quiet) repeat (12 * int'(bt)) push_tick(1'b1, 1'b0);
  endtask

  // Main sequence
  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // at the reset rate: request, request while busy, ack with nothing ready
    send_tick(mk_tick(1'b1, 1'b0, 8'h00, 1'b0));
    send_tick(mk_tick(1'b1, 1'b1, 8'hFF, 1'b0));
    send_tick(mk_tick(1'b1, 1'b1, 8'h00, 1'b0));
    send_tick(mk_tick(1'b1, 1'b0, 8'h5A, 1'b1));
    send_tick(mk_tick(1'b1, 1'b1, 8'hFF, 1'b1));
    drain();

    // shortest bit: transmit count past the new period, one-tick start delay
    write_bit_time(TIMER_WIDTH'(4));
    send_tick(mk_tick(1'b0, 1'b0, 8'h00, 1'b0));
    send_tick(mk_tick(1'b1, 1'b0, 8'h00, 1'b0));
    send_tick(mk_tick(1'b1, 1'b1, 8'hA5, 1'b0));
    send_tick(mk_tick(1'b0, 1'b1, 8'hFF, 1'b1));
    send_tick(mk_tick(1'b0, 1'b0, 8'h00, 1'b0));
    send_tick(mk_tick(1'b0, 1'b0, 8'h00, 1'b0));
    send_tick(mk_tick(1'b1, 1'b0, 8'h00, 1'b0));
    repeat (8) send_tick(mk_tick(1'b1, 1'b0, 8'h00, 1'b0));

    // random part across several bit times, the largest one kept brief
    run_phase(TIMER_WIDTH'(4), 150, 1'b0);
    run_phase(TIMER_WIDTH'(5), 130, 1'b0);
    run_phase(TIMER_WIDTH'(6), 130, 1'b0);
    run_phase(TIMER_WIDTH'($urandom_range(4, 16)), 120, 1'b0);
    run_phase(TIMER_WIDTH'(7), 120, 1'b0);
    run_phase(TIMER_WIDTH'(16'hFFFF), 100, 1'b1);
    run_phase(TIMER_WIDTH'(4), 130, 1'b0);
    run_phase(TIMER_WIDTH'(11), 120, 1'b0);
    run_phase(TIMER_WIDTH'($urandom_range(4, 16)), 120, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: uart_8n1_bit_timed_transceiver.f
rtl/uart_pkg.sv
rtl/uart_tx_core.sv
rtl/uart_rx_core.sv
rtl/uart_8n1_bit_timed_transceiver.sv
tb/tb.sv
